// ----- rtl/eci_pkg.sv -----
package eci_pkg;

  localparam int TIME_W     = 16;
  localparam int DUR_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    MODE_UNDEF       = 4'd0,
    MODE_LINEAR      = 4'd1,
    MODE_QUAD_IN     = 4'd2,
    MODE_QUAD_OUT    = 4'd3,
    MODE_QUAD_INOUT  = 4'd4,
    MODE_BACK_IN     = 4'd5,
    MODE_BACK_OUT    = 4'd6,
    MODE_BACK_INOUT  = 4'd7,
    MODE_EL_IN       = 4'd8,
    MODE_EL_OUT      = 4'd9,
    MODE_EL_INOUT    = 4'd10
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUR  = 1'd1;

  localparam mode_t            MODE_RESET = MODE_LINEAR;
  localparam logic [DUR_W-1:0] DUR_RESET  = 16'd1000;

  // curve constants with 30 fraction bits
  localparam longint K_BACK      = 64'sd1827057613;
  localparam longint K_BACK2     = 64'sd2786262860;
  localparam longint K_EL_SHIFT  = 64'sd80530637;
  localparam longint K_EL_INV    = 64'sd3579139413;
  localparam longint K_EIO_SHIFT = 64'sd120795955;
  localparam longint K_EIO_INV   = 64'sd2386092942;
  localparam longint K_E1        = 64'sd747109561;
  localparam longint K_E2        = 64'sd241699285;
  localparam longint K_E3        = 64'sd84932978;
  localparam longint K_S1        = 64'sd1686629713;
  localparam longint K_S3        = 64'sd688904866;
  localparam longint K_S5        = 64'sd76016977;

  // round a 30-fraction-bit constant half up to frac bits
  function automatic longint cq(input longint c30, input int frac);
    longint r;
    r = (c30 + (longint'(1) << (29 - frac))) >>> (30 - frac);
    return r;
  endfunction

endpackage

// ----- rtl/eci_item_if.sv -----
interface eci_item_if #(
  parameter int VALUE_BITS = 24
);
  logic                                 valid;
  logic                                 ready;
  logic        [eci_pkg::TIME_W-1:0]    elapsed_ms;
  logic signed [VALUE_BITS-1:0]         start_value;
  logic signed [VALUE_BITS-1:0]         end_value;

  modport source (output valid, elapsed_ms, start_value, end_value, input ready);
  modport sink   (input valid, elapsed_ms, start_value, end_value, output ready);
endinterface

// ----- rtl/eci_result_if.sv -----
interface eci_result_if #(
  parameter int VALUE_BITS = 24,
  parameter int FRAC_BITS  = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;
  logic signed [FRAC_BITS+1:0]  eased_progress;
  logic                         saturated;

  modport source (output valid, value, eased_progress, saturated, input ready);
  modport sink   (input valid, value, eased_progress, saturated, output ready);
endinterface

// ----- rtl/eci_cfg_if.sv -----
interface eci_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [eci_pkg::CFG_IDX_W-1:0]     index;
  logic [eci_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/eci_front.sv -----
module eci_front #(
  parameter int VALUE_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  eci_item_if.sink                         item,
  input  logic [eci_pkg::DUR_W-1:0]        duration_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [FRAC_BITS+1:0]      progress,
  output logic signed [VALUE_BITS-1:0]     start_value,
  output logic signed [VALUE_BITS-1:0]     end_value
);
  import eci_pkg::*;

  localparam int NS = FRAC_BITS + 1;
  localparam int EW = FRAC_BITS + 2;

  logic                          vld   [NS];
  logic [DUR_W-1:0]              rem   [NS];
  logic [FRAC_BITS-1:0]          quo   [NS];
  logic                          whole [NS];
  logic signed [VALUE_BITS-1:0]  sa    [NS];
  logic signed [VALUE_BITS-1:0]  sb    [NS];
  logic [DUR_W:0]                trial [NS];
  logic                          ge    [NS];
  logic                          adv;

  assign adv        = !vld[NS-1] || out_ready;
  assign item.ready = adv;

  // one quotient bit per stage after the first, restoring division of a fraction below one
  always_comb begin
    trial[0] = '0;
    ge[0]    = 1'b0;
    for (int k = 1; k < NS; k++) begin
      trial[k] = {rem[k-1], 1'b0};
      ge[k]    = trial[k] >= {1'b0, duration_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= item.valid;
      for (int k = 1; k < NS; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]   <= item.elapsed_ms;
      whole[0] <= item.elapsed_ms >= duration_ms;
      quo[0]   <= '0;
      sa[0]    <= item.start_value;
      sb[0]    <= item.end_value;
      for (int k = 1; k < NS; k++) begin
        rem[k]   <= ge[k] ? DUR_W'(trial[k] - {1'b0, duration_ms}) : trial[k][DUR_W-1:0];
        quo[k]   <= {quo[k-1][FRAC_BITS-2:0], ge[k]};
        whole[k] <= whole[k-1];
        sa[k]    <= sa[k-1];
        sb[k]    <= sb[k-1];
      end
    end
  end

  assign out_valid   = vld[NS-1];
  assign progress    = whole[NS-1] ? EW'(longint'(1) << FRAC_BITS) : {2'b00, quo[NS-1]};
  assign start_value = sa[NS-1];
  assign end_value   = sb[NS-1];

endmodule

// ----- rtl/eci_queue.sv -----
module eci_queue #(
  parameter int WIDTH = 66
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import eci_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  assign push_ready = count != (AW+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ----- rtl/eci_back.sv -----
module eci_back #(
  parameter int VALUE_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  eci_pkg::mode_t                easing_mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [FRAC_BITS+1:0]   progress,
  input  logic signed [VALUE_BITS-1:0]  start_value,
  input  logic signed [VALUE_BITS-1:0]  end_value,
  eci_result_if.source                  result
);
  import eci_pkg::*;

  localparam int NS = 13;
  localparam int QW = FRAC_BITS + 8;
  localparam int EW = FRAC_BITS + 2;
  localparam int VB = VALUE_BITS;
  localparam int XW = VB + 3;
  localparam int PW = VB + 1 + EW;

  localparam logic signed [QW-1:0] ONE   = QW'(longint'(1) << FRAC_BITS);
  localparam logic signed [QW-1:0] TWO   = QW'(longint'(2) << FRAC_BITS);
  localparam logic signed [QW-1:0] C_BK  = QW'(cq(K_BACK, FRAC_BITS));
  localparam logic signed [QW-1:0] C_BK2 = QW'(cq(K_BACK2, FRAC_BITS));
  localparam logic signed [QW-1:0] C_ELS = QW'(cq(K_EL_SHIFT, FRAC_BITS));
  localparam logic signed [QW-1:0] C_ELI = QW'(cq(K_EL_INV, FRAC_BITS));
  localparam logic signed [QW-1:0] C_EIS = QW'(cq(K_EIO_SHIFT, FRAC_BITS));
  localparam logic signed [QW-1:0] C_EII = QW'(cq(K_EIO_INV, FRAC_BITS));
  localparam logic signed [QW-1:0] C_E1  = QW'(cq(K_E1, FRAC_BITS));
  localparam logic signed [QW-1:0] C_E2  = QW'(cq(K_E2, FRAC_BITS));
  localparam logic signed [QW-1:0] C_E3  = QW'(cq(K_E3, FRAC_BITS));
  localparam logic signed [QW-1:0] C_S1  = QW'(cq(K_S1, FRAC_BITS));
  localparam logic signed [QW-1:0] C_S3  = QW'(cq(K_S3, FRAC_BITS));
  localparam logic signed [QW-1:0] C_S5  = QW'(cq(K_S5, FRAC_BITS));
  localparam logic signed [QW-1:0] E_MAX = TWO - QW'(1);
  localparam logic signed [QW-1:0] E_MIN = -TWO;
  localparam logic signed [XW-1:0] V_MAX = XW'((longint'(1) << (VB - 1)) - 1);
  localparam logic signed [XW-1:0] V_MIN = -V_MAX - XW'(1);

  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] x,
                                                input logic signed [QW-1:0] y);
    logic signed [2*QW-1:0] pr;
    pr = x * y;
    pr = pr + (2*QW)'(longint'(1) << (FRAC_BITS - 1));
    return QW'(pr >>> FRAC_BITS);
  endfunction

  function automatic logic signed [QW-1:0] halfq(input logic signed [QW-1:0] x);
    return (x + QW'(1)) >>> 1;
  endfunction

  function automatic logic signed [QW-1:0] ten(input logic signed [QW-1:0] x);
    return (x <<< 3) + (x <<< 1);
  endfunction

  logic vld [NS];
  logic adv;

  logic signed [VB-1:0] a_d  [NS];
  logic signed [VB-1:0] b_d  [NS];
  logic signed [QW-1:0] p_d  [NS];
  logic                 lw_d [NS];
  logic                 ng_d [NS];
  logic                 dn_d [NS];

  logic signed [QW-1:0] qa1, qb1, x1, k1, ea1, u1, inv1;
  logic                 plus1;
  logic signed [QW-1:0] qr2, bsq2, blin2, k2, eh2, f2, sh2, st2;
  logic                 plus2;
  logic signed [QW-1:0] ec3, br3, eh3, f3, sh3, z3;
  logic                 sg3;
  logic signed [QW-1:0] ec4, eh4, z2_4, z4, sh4;
  logic                 sg4;
  logic signed [QW-1:0] ec5, ev5, w5, z2_5, z5;
  logic                 sg5;
  logic signed [QW-1:0] ec6, ev6, w2_6, z6;
  logic                 sg6;
  logic signed [QW-1:0] ec7, ev7, s7;
  logic signed [QW-1:0] ec8, prod8;
  logic signed [QW-1:0] ec9;
  logic signed [EW-1:0] e10, e11, e12;
  logic signed [VB:0]   diff10;
  logic signed [XW-1:0] pv11;
  logic signed [VB-1:0] value12;
  logic                 sat12;

  // combinational stage values
  logic signed [QW-1:0] c_p0, c_t, c_q, c_q2;
  logic                 c_low;
  logic signed [QW-1:0] c_qa, c_qb, c_x, c_k, c_ea, c_u, c_inv;
  logic                 c_plus;
  logic signed [QW-1:0] c_n, c_f, c_sh;
  logic signed [QW-1:0] c_qo, c_ec3, c_bc;
  logic [FRAC_BITS-1:0] c_xx;
  logic signed [QW-1:0] c_z0, c_z;
  logic signed [QW-1:0] c_bo, c_ec4, c_ev, c_s, c_eo, c_ec9, c_ecl;
  logic signed [PW-1:0] c_pv;
  logic signed [XW-1:0] c_v;

  assign adv      = !vld[NS-1] || result.ready;
  assign in_ready = adv;

  always_comb begin
    c_p0  = QW'(p_d[0]);
    c_t   = c_p0 <<< 1;
    c_low = c_t < ONE;
    c_q   = c_p0 - ONE;
    c_q2  = c_t - ONE;

    case (easing_mode)
      MODE_QUAD_IN: begin
        c_qa = c_p0;
        c_qb = c_p0;
      end
      MODE_QUAD_OUT: begin
        c_qa = c_p0;
        c_qb = TWO - c_p0;
      end
      default: begin
        c_qa = c_low ? c_t : c_q2;
        c_qb = c_low ? c_t : c_q2 - TWO;
      end
    endcase

    case (easing_mode)
      MODE_BACK_IN: begin
        c_x    = c_p0;
        c_k    = C_BK;
        c_plus = 1'b0;
      end
      MODE_BACK_OUT: begin
        c_x    = c_q;
        c_k    = C_BK;
        c_plus = 1'b1;
      end
      default: begin
        c_x    = c_low ? c_t : c_t - TWO;
        c_k    = C_BK2;
        c_plus = !c_low;
      end
    endcase

    case (easing_mode)
      MODE_EL_IN: begin
        c_ea  = ten(c_q);
        c_u   = c_q - C_ELS;
        c_inv = C_ELI;
      end
      MODE_EL_OUT: begin
        c_ea  = -ten(c_p0);
        c_u   = c_p0 - C_ELS;
        c_inv = C_ELI;
      end
      default: begin
        c_ea  = (c_q2 < 0) ? ten(c_q2) : -ten(c_q2);
        c_u   = c_q2 - C_EIS;
        c_inv = C_EII;
      end
    endcase

    // exponent split into whole and fraction parts
    c_n  = ea1 >>> FRAC_BITS;
    c_f  = {{(QW-FRAC_BITS){1'b0}}, ea1[FRAC_BITS-1:0]};
    c_sh = -c_n;

    c_qo = (easing_mode == MODE_QUAD_INOUT)
         ? (lw_d[2] ? halfq(qr2) : halfq(ONE - qr2)) : qr2;
    case (easing_mode) inside
      MODE_LINEAR: c_ec3 = p_d[2];
      MODE_QUAD_IN, MODE_QUAD_OUT, MODE_QUAD_INOUT: c_ec3 = c_qo;
      default: c_ec3 = ONE;
    endcase
    c_bc = plus2 ? blin2 + k2 : blin2 - k2;

    // quarter wave reduction
    c_xx = st2[FRAC_BITS-1:0];
    c_z0 = {{(QW-FRAC_BITS){1'b0}}, c_xx[FRAC_BITS-3:0], 2'b00};
    c_z  = c_xx[FRAC_BITS-2] ? ONE - c_z0 : c_z0;

    case (easing_mode)
      MODE_BACK_IN:  c_bo = br3;
      MODE_BACK_OUT: c_bo = br3 + ONE;
      default:       c_bo = halfq(lw_d[3] ? br3 : br3 + TWO);
    endcase
    c_ec4 = (easing_mode inside {MODE_BACK_IN, MODE_BACK_OUT, MODE_BACK_INOUT}) ? c_bo : ec3;

    c_ev = (sh4 >= QW'(QW)) ? '0 : ((ONE + eh4) >>> sh4);

    c_s = mulq(z6, C_S1 - w2_6);

    case (easing_mode)
      MODE_EL_IN:  c_eo = -prod8;
      MODE_EL_OUT: c_eo = prod8 + ONE;
      default:     c_eo = ng_d[8] ? -halfq(prod8) : halfq(prod8) + ONE;
    endcase
    if (dn_d[8]) c_eo = ONE;
    c_ec9 = (easing_mode inside {MODE_EL_IN, MODE_EL_OUT, MODE_EL_INOUT}) ? c_eo : ec8;

    if (ec9 > E_MAX) c_ecl = E_MAX;
    else if (ec9 < E_MIN) c_ecl = E_MIN;
    else c_ecl = ec9;

    c_pv = diff10 * e10;
    c_pv = c_pv + PW'(longint'(1) << (FRAC_BITS - 1));
    c_pv = c_pv >>> FRAC_BITS;

    c_v = XW'(a_d[11]) + pv11;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < NS; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_d[0]  <= start_value;
      b_d[0]  <= end_value;
      p_d[0]  <= QW'(progress);
      for (int k = 1; k < NS; k++) begin
        a_d[k]  <= a_d[k-1];
        b_d[k]  <= b_d[k-1];
        p_d[k]  <= p_d[k-1];
      end
      for (int k = 2; k < NS; k++) begin
        lw_d[k] <= lw_d[k-1];
        ng_d[k] <= ng_d[k-1];
        dn_d[k] <= dn_d[k-1];
      end
      lw_d[1] <= c_low;
      ng_d[1] <= c_q2 < 0;
      dn_d[1] <= c_p0 == ONE;

      qa1   <= c_qa;
      qb1   <= c_qb;
      x1    <= c_x;
      k1    <= c_k;
      plus1 <= c_plus;
      ea1   <= c_ea;
      u1    <= c_u;
      inv1  <= c_inv;

      qr2   <= mulq(qa1, qb1);
      bsq2  <= mulq(x1, x1);
      blin2 <= mulq(k1 + ONE, x1);
      k2    <= k1;
      plus2 <= plus1;
      eh2   <= mulq(c_f, C_E3);
      f2    <= c_f;
      sh2   <= c_sh;
      st2   <= mulq(u1, inv1);

      ec3 <= c_ec3;
      br3 <= mulq(bsq2, c_bc);
      eh3 <= mulq(f2, C_E2 + eh2);
      f3  <= f2;
      sh3 <= sh2;
      z3  <= c_z;
      sg3 <= c_xx[FRAC_BITS-1];

      ec4  <= c_ec4;
      eh4  <= mulq(f3, C_E1 + eh3);
      z2_4 <= mulq(z3, z3);
      z4   <= z3;
      sh4  <= sh3;
      sg4  <= sg3;

      ec5  <= ec4;
      ev5  <= c_ev;
      w5   <= mulq(z2_4, C_S5);
      z2_5 <= z2_4;
      z5   <= z4;
      sg5  <= sg4;

      ec6  <= ec5;
      ev6  <= ev5;
      w2_6 <= mulq(z2_5, C_S3 - w5);
      z6   <= z5;
      sg6  <= sg5;

      ec7 <= ec6;
      ev7 <= ev6;
      s7  <= sg6 ? -c_s : c_s;

      ec8   <= ec7;
      prod8 <= mulq(ev7, s7);

      ec9 <= c_ec9;

      e10    <= EW'(c_ecl);
      diff10 <= (VB+1)'(b_d[9]) - (VB+1)'(a_d[9]);

      e11  <= e10;
      pv11 <= XW'(c_pv);

      e12 <= e11;
      if (c_v > V_MAX) begin
        value12 <= VB'(V_MAX);
        sat12   <= 1'b1;
      end else if (c_v < V_MIN) begin
        value12 <= VB'(V_MIN);
        sat12   <= 1'b1;
      end else begin
        value12 <= VB'(c_v);
        sat12   <= 1'b0;
      end
    end
  end

  assign result.valid          = vld[NS-1];
  assign result.value          = value12;
  assign result.eased_progress = e12;
  assign result.saturated      = sat12;

endmodule

// ----- rtl/easing_curve_interpolator.sv -----
// channel   modport  handshake      payload
// item      sink     valid/ready    elapsed_ms, start_value, end_value
// result    source   valid/ready    value, eased_progress, saturated
// cfg       sink     valid/ready=1  index, data
//
// one request per cycle sustained while result.ready stays high; FRAC_BITS + 1 divider
// stages, a registered pass through the four-entry queue, then 13 easing and blend stages
// reset clears the valid bits, the queue and the registers (linear, 1000 ms)
// a stalled result holds the back pipeline; the queue then absorbs the divider
// until it fills, after which item.ready drops
module easing_curve_interpolator #(
  parameter int VALUE_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  eci_item_if.sink     item,
  eci_result_if.source result,
  eci_cfg_if.sink      cfg
);
  import eci_pkg::*;

  localparam int EW = FRAC_BITS + 2;
  localparam int QD = EW + 2 * VALUE_BITS;

  mode_t                   easing_mode;
  logic [DUR_W-1:0]        duration_ms;

  logic                    f_valid;
  logic                    f_ready;
  logic signed [EW-1:0]    f_progress;
  logic signed [VALUE_BITS-1:0] f_start;
  logic signed [VALUE_BITS-1:0] f_end;
  logic [QD-1:0]           q_data;
  logic                    q_valid;
  logic                    q_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      easing_mode <= MODE_RESET;
      duration_ms <= DUR_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MODE: easing_mode <= mode_t'(cfg.data[3:0]);
        REG_DUR:  duration_ms <= cfg.data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  eci_front #(
    .VALUE_BITS(VALUE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .duration_ms(duration_ms),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .progress   (f_progress),
    .start_value(f_start),
    .end_value  (f_end)
  );

  eci_queue #(
    .WIDTH(QD)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data ({f_progress, f_start, f_end}),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  eci_back #(
    .VALUE_BITS(VALUE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .easing_mode(easing_mode),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .progress   (q_data[QD-1 -: EW]),
    .start_value(q_data[2*VALUE_BITS-1 -: VALUE_BITS]),
    .end_value  (q_data[VALUE_BITS-1:0]),
    .result     (result)
  );

endmodule
